[rtl/bssc_pkg.sv]
// Shared constants and types for the binary subarray sum counter.
`default_nettype none
package bssc_pkg;

   localparam int DefaultMaxLen = 32768;
   localparam int TargetW       = 16;
   localparam int CountW        = 30;
   localparam int QueueDepth    = 4;
   localparam int QueueCntW     = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [CountW-1:0] addend;
      logic              last;
      logic              too_long;
   } item_type;

endpackage
`default_nettype wire

[rtl/bssc_front.sv]
// Front end: request intake, prefix tracking, table access and classification.
`default_nettype none
module bssc_front #(
   parameter int MAX_LEN = bssc_pkg::DefaultMaxLen
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_bit_value,
   input  wire logic                             req_is_last,
   input  wire logic [bssc_pkg::TargetW-1:0]     target,
   input  wire logic [bssc_pkg::QueueCntW-1:0]   q_count,
   output logic                                  push,
   output bssc_pkg::item_type                    push_item
);
   import bssc_pkg::*;

   localparam int CntW   = $clog2(MAX_LEN + 1);
   localparam int EntryW = $clog2(MAX_LEN + 2);
   localparam int AddrW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CmpW   = (CntW > TargetW) ? CntW : TargetW;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'b001,
      KIND_DIRECT = 3'b010,
      KIND_MEM    = 3'b100
   } kind_type;

   logic [EntryW-1:0] table_mem [MAX_LEN];

   logic [CntW-1:0]   prefix_ff, prefix_in;
   logic [CntW-1:0]   elem_cnt_ff, elem_cnt_in;
   logic [EntryW-1:0] cur_cnt_ff, cur_cnt_in;
   logic              ovf_ff, ovf_in;

   logic              b_valid_ff;
   kind_type          b_kind_ff;
   logic [EntryW-1:0] b_direct_ff;
   logic              b_last_ff;
   logic              b_ovf_ff;
   logic [EntryW-1:0] rdata_ff;

   logic              accept;
   logic              cnt_ok;
   logic [CntW-1:0]   new_prefix;
   logic [CmpW-1:0]   np_ext;
   logic [CmpW-1:0]   tg_ext;
   logic [CmpW-1:0]   look;
   kind_type          kind;
   logic [EntryW-1:0] direct_val;
   logic [QueueCntW:0] occupancy;
   logic [EntryW-1:0] addend;

   assign occupancy = {1'b0, q_count} + (QueueCntW + 1)'(b_valid_ff);
   assign req_stall = occupancy >= (QueueCntW + 1)'(QueueDepth);
   assign accept    = req_valid && !req_stall;

   assign cnt_ok     = elem_cnt_ff != CntW'(MAX_LEN);
   assign new_prefix = prefix_ff + CntW'(req_bit_value);
   assign np_ext     = CmpW'(new_prefix);
   assign tg_ext     = CmpW'(target);
   assign look       = np_ext - tg_ext;

   // Table holds counts of prefixes already left; the current one lives in cur_cnt.
   always_comb begin
      kind       = KIND_NONE;
      direct_val = '0;
      if (!cnt_ok) begin
         kind = KIND_NONE;
      end else if (target == '0) begin
         kind       = KIND_DIRECT;
         direct_val = req_bit_value ? '0 : cur_cnt_ff;
      end else if (np_ext < tg_ext) begin
         kind = KIND_NONE;
      end else if (target == TargetW'(1) && req_bit_value) begin
         kind       = KIND_DIRECT;
         direct_val = cur_cnt_ff;
      end else begin
         kind = KIND_MEM;
      end
   end

   always_comb begin
      prefix_in   = prefix_ff;
      elem_cnt_in = elem_cnt_ff;
      cur_cnt_in  = cur_cnt_ff;
      ovf_in      = ovf_ff;
      if (accept) begin
         if (req_is_last) begin
            prefix_in   = '0;
            elem_cnt_in = '0;
            cur_cnt_in  = EntryW'(1);
            ovf_in      = 1'b0;
         end else if (cnt_ok) begin
            prefix_in   = new_prefix;
            elem_cnt_in = elem_cnt_ff + CntW'(1);
            cur_cnt_in  = req_bit_value ? EntryW'(1) : cur_cnt_ff + EntryW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff   <= '0;
         elem_cnt_ff <= '0;
         cur_cnt_ff  <= EntryW'(1);
         ovf_ff      <= 1'b0;
         b_valid_ff  <= 1'b0;
      end else begin
         prefix_ff   <= prefix_in;
         elem_cnt_ff <= elem_cnt_in;
         cur_cnt_ff  <= cur_cnt_in;
         ovf_ff      <= ovf_in;
         b_valid_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_kind_ff   <= kind;
         b_direct_ff <= direct_val;
         b_last_ff   <= req_is_last;
         b_ovf_ff    <= ovf_ff || !cnt_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cnt_ok && req_bit_value) begin
         table_mem[prefix_ff[AddrW-1:0]] <= cur_cnt_ff;
      end
      if (accept) begin
         rdata_ff <= table_mem[look[AddrW-1:0]];
      end
   end

   always_comb begin
      case (b_kind_ff)
         KIND_MEM:    addend = rdata_ff;
         KIND_DIRECT: addend = b_direct_ff;
         default:     addend = '0;
      endcase
   end

   assign push               = b_valid_ff;
   assign push_item.addend   = CountW'(addend);
   assign push_item.last     = b_last_ff;
   assign push_item.too_long = b_ovf_ff;

endmodule
`default_nettype wire

[rtl/bssc_queue.sv]
// Short queue between front and back ends.
`default_nettype none
module bssc_queue (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire bssc_pkg::item_type             push_item,
   input  wire logic                           pop,
   output logic                                head_valid,
   output bssc_pkg::item_type                  head_item,
   output logic [bssc_pkg::QueueCntW-1:0]      count
);
   import bssc_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   item_type             entries_ff [QueueDepth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntW'(push) - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_item  = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule
`default_nettype wire

[rtl/bssc_back.sv]
// Back end: accumulates addends and registers the response.
`default_nettype none
module bssc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   input  wire bssc_pkg::item_type          head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [bssc_pkg::CountW-1:0]      rsp_subarray_count,
   output logic                             rsp_too_long
);
   import bssc_pkg::*;

   logic [CountW-1:0] total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CountW-1:0] rsp_count_ff;
   logic              rsp_too_long_ff;
   logic [CountW-1:0] sum;
   logic              load;

   assign sum  = total_ff + head_item.addend;
   assign pop  = head_valid && (!head_item.last || !rsp_valid_ff || !rsp_stall);
   assign load = pop && head_item.last;

   always_comb begin
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         total_in = head_item.last ? '0 : sum;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_count_ff    <= sum;
         rsp_too_long_ff <= head_item.too_long;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_subarray_count = rsp_count_ff;
   assign rsp_too_long       = rsp_too_long_ff;

endmodule
`default_nettype wire

[rtl/binary_subarray_sum_counter_core.sv]
// Top level of the binary subarray sum counter.
// Throughput: one bit request per cycle unless stalled, set by the single write
// and read port of the prefix table. Responses pass the front end, queue and back end.
// Reset clears all control state and sets the target to zero; the prefix table is
// not cleared, as an entry is only read after it has been written in the same array.
`default_nettype none
module binary_subarray_sum_counter_core #(
   parameter int MAX_LEN = bssc_pkg::DefaultMaxLen
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_bit_value,
   input  wire logic                          req_is_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [bssc_pkg::CountW-1:0]        rsp_subarray_count,
   output logic                               rsp_too_long,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bssc_pkg::TargetW-1:0]  csr_target_sum
);
   import bssc_pkg::*;

   logic [TargetW-1:0]   target_ff, target_in;
   logic                 push;
   item_type             push_item;
   logic                 pop;
   logic                 head_valid;
   item_type             head_item;
   logic [QueueCntW-1:0] q_count;

   assign csr_ready = 1'b1;
   assign target_in = (csr_valid && csr_ready) ? csr_target_sum : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   bssc_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_bit_value (req_bit_value),
      .req_is_last   (req_is_last),
      .target        (target_ff),
      .q_count       (q_count),
      .push          (push),
      .push_item     (push_item)
   );

   bssc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (q_count)
   );

   bssc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_subarray_count (rsp_subarray_count),
      .rsp_too_long       (rsp_too_long)
   );

`ifndef SYNTHESIS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && q_count == QueueCntW'(QueueDepth)))
      else $error("request queue overflow");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_count != '0)
      else $error("pop from empty queue");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (q_count == QueueCntW'(QueueDepth)) |-> req_stall)
      else $error("request accepted with full queue");
`endif

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the binary subarray sum counter core.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bssc_pkg::*;

   localparam int MaxLen      = DefaultMaxLen;
   localparam int PerPhase    = 95;
   localparam int NumPhases   = 15;
   localparam int HoldLen     = 400;
   localparam int DrainCycles = 12;
   localparam int CycleLimit  = 1000000;

   typedef struct packed {
      logic [CountW-1:0] count;
      logic              too_long;
   } result_type;

   typedef struct packed {
      logic [TargetW-1:0] target;
      logic               bit_value;
      logic               is_last;
      logic               typed;
      logic [CountW-1:0]  count;
      logic               too_long;
   } dir_row_type;

   localparam dir_row_type DirectedRows [0:23] = '{
      '{16'd0,     1'b1, 1'b1, 1'b1, 30'd0, 1'b0},
      '{16'd0,     1'b0, 1'b1, 1'b1, 30'd1, 1'b0},
      '{16'd0,     1'b0, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd0,     1'b0, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd0,     1'b0, 1'b1, 1'b1, 30'd6, 1'b0},
      '{16'd1,     1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd1,     1'b0, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd1,     1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd1,     1'b1, 1'b1, 1'b0, 30'd0, 1'b0},
      '{16'd1,     1'b0, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd1,     1'b0, 1'b1, 1'b0, 30'd0, 1'b0},
      '{16'hFFFF,  1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'hFFFF,  1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'hFFFF,  1'b1, 1'b1, 1'b1, 30'd0, 1'b0},
      '{16'h8000,  1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'h8000,  1'b1, 1'b1, 1'b1, 30'd0, 1'b0},
      '{16'd2,     1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd2,     1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd2,     1'b0, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd2,     1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd2,     1'b1, 1'b1, 1'b0, 30'd0, 1'b0},
      '{16'd3,     1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd3,     1'b1, 1'b0, 1'b0, 30'd0, 1'b0},
      '{16'd3,     1'b1, 1'b1, 1'b1, 30'd1, 1'b0}
   };

   localparam logic [TargetW-1:0] PhaseTargets [0:NumPhases-1] = '{
      16'd1, 16'd0, 16'd2, 16'd3, 16'hFFFF, 16'd1, 16'd0, 16'd4,
      16'h8000, 16'd2, 16'd1, 16'd0, 16'h5A5A, 16'd3, 16'd1
   };

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_bit_value      = 1'b0;
   logic                req_is_last        = 1'b0;
   logic                rsp_stall          = 1'b0;
   logic                csr_valid          = 1'b0;
   logic [TargetW-1:0]  csr_target_sum     = '0;
   logic                req_stall;
   logic                rsp_valid;
   logic [CountW-1:0]   rsp_subarray_count;
   logic                rsp_too_long;
   logic                csr_ready;

   binary_subarray_sum_counter_core #(.MAX_LEN(MaxLen)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bit_value      (req_bit_value),
      .req_is_last        (req_is_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_subarray_count (rsp_subarray_count),
      .rsp_too_long       (rsp_too_long),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_target_sum     (csr_target_sum)
   );

   // predictor state
   int unsigned         seen_count [0:MaxLen];
   int unsigned         prefix_now;
   int unsigned         elems_now;
   logic [CountW-1:0]   total_now;
   logic                overrun_now;
   logic [TargetW-1:0]  target_now;

   result_type          pending_results [$];
   int                  error_count   = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  hold_asked    = 0;
   int                  hold_given    = 0;
   int                  hold_left     = 0;
   int unsigned         cycle_count   = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
      error_count++;
   endtask

   function automatic void clear_array();
      for (int i = 0; i <= prefix_now; i++) seen_count[i] = 0;
      seen_count[0] = 1;
      prefix_now    = 0;
      elems_now     = 0;
      total_now     = '0;
      overrun_now   = 1'b0;
   endfunction

   // prefix-sum count: adds entries seen at prefix minus target
   function automatic bit tally_bit(input logic b, input logic l, output result_type res);
      res = '0;
      if (elems_now < MaxLen) begin
         elems_now++;
         prefix_now += b;
         if (prefix_now > MaxLen) prefix_now = MaxLen;
         if (prefix_now >= target_now)
            total_now = total_now + CountW'(seen_count[prefix_now - target_now]);
         seen_count[prefix_now]++;
      end else begin
         overrun_now = 1'b1;
      end
      if (!l) return 1'b0;
      res.count    = total_now;
      res.too_long = overrun_now;
      clear_array();
      return 1'b1;
   endfunction

   // response side: checks and random stall, with long hold-off on request
   always @(posedge clock) begin
      result_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response count", -1, rsp_subarray_count);
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_subarray_count !== exp_r.count)
                  report_mismatch("subarray_count", exp_r.count, rsp_subarray_count);
               if (rsp_too_long !== exp_r.too_long)
                  report_mismatch("too_long", exp_r.too_long, rsp_too_long);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_asked != hold_given) begin
            hold_given++;
            hold_left = HoldLen;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   task automatic send_bit(input logic b, input logic l, input logic typed,
                           input logic [CountW-1:0] t_count, input logic t_too_long);
      result_type res;
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bit_value <= b;
      req_is_last   <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (tally_bit(b, l, res)) begin
         if (typed) begin
            res.count    = t_count;
            res.too_long = t_too_long;
         end
         pending_results.push_back(res);
      end
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_target(input logic [TargetW-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait_drained();
      csr_valid      <= 1'b1;
      csr_target_sum <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      target_now = value;
      csr_valid <= 1'b0;
   endtask

   task automatic send_array(input int len, input int one_pct);
      for (int i = 0; i < len; i++)
         send_bit($urandom_range(0, 99) < one_pct, i == len - 1, 1'b0, '0, 1'b0);
   endtask

   initial begin
      int len;
      int sent;
      int one_pct;
      for (int i = 0; i <= MaxLen; i++) seen_count[i] = 0;
      prefix_now = 0;
      clear_array();
      target_now = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DirectedRows[r]) begin
         if (DirectedRows[r].target != target_now) write_target(DirectedRows[r].target);
         send_bit(DirectedRows[r].bit_value, DirectedRows[r].is_last, DirectedRows[r].typed,
                  DirectedRows[r].count, DirectedRows[r].too_long);
      end

      for (int ph = 0; ph < NumPhases; ph++) begin
         if (ph < 5) begin
            send_idle_pct = 26;
            recv_idle_pct = 53;
         end else if (ph < 10) begin
            send_idle_pct = 53;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_target(PhaseTargets[ph]);
         if (ph == 10) hold_asked++;
         sent = 0;
         while (sent < PerPhase) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0: one_pct = 10;
               1: one_pct = 90;
               default: one_pct = 50;
            endcase
            send_array(len, one_pct);
            sent += len;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait_drained();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
